FILE: sv/lts_pkg.sv
// Shared types, constants and keyword tables for the Lox token scanner.
// No dependencies; imported by lts_scan, lts_out_queue and lox_token_scanner.
package lts_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 24;
  localparam int LENGTH_BITS = 16;
  localparam int KW_COUNT    = 16;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] POS_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  // Lexer mode between bytes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_STRING  = 4'd3,
    MODE_COMMENT = 4'd4,
    MODE_BANG    = 4'd5,
    MODE_EQUAL   = 4'd6,
    MODE_GREATER = 4'd7,
    MODE_LESS    = 4'd8,
    MODE_SLASH   = 4'd9
  } mode_e;

  // Token kind codes
  localparam logic [5:0] KIND_LPAREN   = 6'd0;
  localparam logic [5:0] KIND_RPAREN   = 6'd1;
  localparam logic [5:0] KIND_LBRACE   = 6'd2;
  localparam logic [5:0] KIND_RBRACE   = 6'd3;
  localparam logic [5:0] KIND_COMMA    = 6'd4;
  localparam logic [5:0] KIND_DOT      = 6'd5;
  localparam logic [5:0] KIND_MINUS    = 6'd6;
  localparam logic [5:0] KIND_PLUS     = 6'd7;
  localparam logic [5:0] KIND_SEMI     = 6'd8;
  localparam logic [5:0] KIND_SLASH    = 6'd9;
  localparam logic [5:0] KIND_STAR     = 6'd10;
  localparam logic [5:0] KIND_BANG     = 6'd11;
  localparam logic [5:0] KIND_BANG_EQ  = 6'd12;
  localparam logic [5:0] KIND_EQUAL    = 6'd13;
  localparam logic [5:0] KIND_EQ_EQ    = 6'd14;
  localparam logic [5:0] KIND_GREATER  = 6'd15;
  localparam logic [5:0] KIND_GT_EQ    = 6'd16;
  localparam logic [5:0] KIND_LESS     = 6'd17;
  localparam logic [5:0] KIND_LT_EQ    = 6'd18;
  localparam logic [5:0] KIND_IDENT    = 6'd19;
  localparam logic [5:0] KIND_STRING   = 6'd20;
  localparam logic [5:0] KIND_NUMBER   = 6'd21;
  localparam logic [5:0] KIND_KEYWORD0 = 6'd22;
  localparam logic [5:0] KIND_ERROR    = 6'd38;
  localparam logic [5:0] KIND_EOF      = 6'd39;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  // Keywords, right-aligned in 48 bits; order matches the kind codes
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'("and"),   48'("class"),  48'("else"),  48'("false"),
    48'("for"),   48'("fun"),    48'("if"),    48'("nil"),
    48'("or"),    48'("print"),  48'("return"), 48'("super"),
    48'("this"),  48'("true"),   48'("var"),   48'("while")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  // One result item
  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [1:0]             err;
    logic                   last;
  } tok_t;

  // Scanner state carried between bytes
  typedef struct packed {
    mode_e                  mode;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] start;
    logic [LINE_BITS-1:0]   line;
    logic [KW_COUNT-1:0]    cand;
  } scan_state_t;

  // Character i of keyword k; valid for i below the keyword length
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] i);
    logic [2:0]  idx;
    logic [47:0] w;
    idx = 3'(KW_LEN[k] - 3'd1 - i);
    w   = KW_TEXT[k] >> {idx, 3'b000};
    return w[7:0];
  endfunction

endpackage

FILE: sv/lts_scan.sv
// Combinational scanner step: next state and up to two tokens for one input.
// Depends on lts_pkg.
module lts_scan import lts_pkg::*; (
  input  scan_state_t state_i,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  output scan_state_t state_o,
  output tok_t        tok0_o,
  output tok_t        tok1_o,
  output logic [1:0]  push_cnt_o
);

  // Saturating token length from start up to end (end may be pos + 1)
  function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [OFFSET_BITS:0] end_v,
                                                     input logic [OFFSET_BITS-1:0] start_v);
    logic [OFFSET_BITS:0] diff;
    diff = end_v - {1'b0, start_v};
    if (|diff[OFFSET_BITS:LENGTH_BITS]) return LEN_MAX;
    return diff[LENGTH_BITS-1:0];
  endfunction

  logic [7:0]             c;
  logic                   is_digit, is_alpha;
  logic [OFFSET_BITS:0]   pos_p1;
  logic [OFFSET_BITS-1:0] ident_n;
  logic                   ident_small;
  logic [KW_COUNT-1:0]    first_mask, cand_more;
  logic [5:0]             ident_kind;

  // pending-token flush
  logic                   fl_valid;
  logic [5:0]             fl_kind;
  logic [1:0]             fl_err;
  // start of a new token at this byte
  mode_e                  sb_mode;
  logic                   sb_line_inc, sb_emit;
  logic [5:0]             sb_kind;
  logic [1:0]             sb_err;
  // tokens completed by this byte or by end of text
  logic                   own_valid;
  logic [5:0]             own_kind;
  logic [LENGTH_BITS-1:0] own_len;
  logic [OFFSET_BITS-1:0] own_start;

  logic                   do_flush, do_sb, line_inc;
  tok_t                   e0, e1;
  logic                   e0_v, e1_v;

  assign c        = char_byte_i;
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign pos_p1   = {1'b0, state_i.pos} + {{OFFSET_BITS{1'b0}}, 1'b1};

  // Keyword candidate tracking and final match
  assign ident_n     = state_i.pos - state_i.start;
  assign ident_small = (ident_n[OFFSET_BITS-1:3] == '0);

  always_comb begin
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      first_mask[k] = (kw_char(k, 3'd0) == c);
      cand_more[k]  = state_i.cand[k] && ident_small && (ident_n[2:0] < KW_LEN[k]) &&
                      (kw_char(k, ident_n[2:0]) == c);
    end
  end

  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (state_i.cand[k] && ident_small && (ident_n[2:0] == KW_LEN[k])) begin
        ident_kind = KIND_KEYWORD0 + 6'(k);
      end
    end
  end

  // Token held pending in the current mode
  always_comb begin
    fl_valid = 1'b1;
    fl_err   = ERR_NONE;
    fl_kind  = KIND_IDENT;
    unique case (state_i.mode)
      MODE_IDENT:   fl_kind = ident_kind;
      MODE_NUMBER:  fl_kind = KIND_NUMBER;
      MODE_STRING:  begin
        fl_kind = KIND_ERROR;
        fl_err  = ERR_UNTERM;
      end
      MODE_BANG:    fl_kind = KIND_BANG;
      MODE_EQUAL:   fl_kind = KIND_EQUAL;
      MODE_GREATER: fl_kind = KIND_GREATER;
      MODE_LESS:    fl_kind = KIND_LESS;
      MODE_SLASH:   fl_kind = KIND_SLASH;
      default:      fl_valid = 1'b0;
    endcase
  end

  // Classify a byte that begins a token
  always_comb begin
    sb_mode     = MODE_IDLE;
    sb_line_inc = 1'b0;
    sb_emit     = 1'b0;
    sb_kind     = KIND_ERROR;
    sb_err      = ERR_NONE;
    if (is_digit) begin
      sb_mode = MODE_NUMBER;
    end else if (is_alpha) begin
      sb_mode = MODE_IDENT;
    end else begin
      unique case (c)
        " ", "\t", "\r": sb_mode = MODE_IDLE;
        "\n": sb_line_inc = 1'b1;
        "\"": sb_mode = MODE_STRING;
        "!":  sb_mode = MODE_BANG;
        "=":  sb_mode = MODE_EQUAL;
        ">":  sb_mode = MODE_GREATER;
        "<":  sb_mode = MODE_LESS;
        "/":  sb_mode = MODE_SLASH;
        "(":  begin sb_emit = 1'b1; sb_kind = KIND_LPAREN; end
        ")":  begin sb_emit = 1'b1; sb_kind = KIND_RPAREN; end
        "{":  begin sb_emit = 1'b1; sb_kind = KIND_LBRACE; end
        "}":  begin sb_emit = 1'b1; sb_kind = KIND_RBRACE; end
        ",":  begin sb_emit = 1'b1; sb_kind = KIND_COMMA; end
        ".":  begin sb_emit = 1'b1; sb_kind = KIND_DOT; end
        "-":  begin sb_emit = 1'b1; sb_kind = KIND_MINUS; end
        "+":  begin sb_emit = 1'b1; sb_kind = KIND_PLUS; end
        ";":  begin sb_emit = 1'b1; sb_kind = KIND_SEMI; end
        "*":  begin sb_emit = 1'b1; sb_kind = KIND_STAR; end
        default: begin
          sb_emit = 1'b1;
          sb_kind = KIND_ERROR;
          sb_err  = ERR_UNKNOWN;
        end
      endcase
    end
  end

  // Mode transitions
  always_comb begin
    state_o   = state_i;
    do_flush  = 1'b0;
    do_sb     = 1'b0;
    line_inc  = 1'b0;
    own_valid = 1'b0;
    own_kind  = KIND_EOF;
    own_start = state_i.start;
    own_len   = sat_len(pos_p1, state_i.start);

    if (end_of_input_i) begin
      do_flush      = 1'b1;
      own_valid     = 1'b1;
      own_kind      = KIND_EOF;
      own_start     = state_i.pos;
      own_len       = '0;
      state_o.mode  = MODE_IDLE;
      state_o.start = state_i.pos;
    end else begin
      unique case (state_i.mode)
        MODE_IDENT: begin
          if (is_alpha || is_digit) state_o.cand = cand_more;
          else begin do_flush = 1'b1; do_sb = 1'b1; end
        end
        MODE_NUMBER: begin
          if (!(is_digit || (c == "."))) begin do_flush = 1'b1; do_sb = 1'b1; end
        end
        MODE_STRING: begin
          if (c == "\"") begin
            own_valid    = 1'b1;
            own_kind     = KIND_STRING;
            state_o.mode = MODE_IDLE;
          end else if (c == "\n") begin
            line_inc = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == "\n") do_sb = 1'b1;
        end
        MODE_BANG, MODE_EQUAL, MODE_GREATER, MODE_LESS: begin
          if (c == "=") begin
            own_valid    = 1'b1;
            own_kind     = fl_kind + 6'd1;
            state_o.mode = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_sb    = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "/") state_o.mode = MODE_COMMENT;
          else begin do_flush = 1'b1; do_sb = 1'b1; end
        end
        default: do_sb = 1'b1;
      endcase

      if (do_sb) begin
        state_o.mode  = sb_mode;
        state_o.start = state_i.pos;
        line_inc      = sb_line_inc;
        if (sb_mode == MODE_IDENT) state_o.cand = first_mask;
      end
      if (state_i.pos != POS_MAX) state_o.pos = pos_p1[OFFSET_BITS-1:0];
    end

    if (line_inc && (state_i.line != LINE_MAX)) state_o.line = state_i.line + 1'b1;
  end

  // Order tokens: flushed one first, then the one started or closed here
  always_comb begin
    e0_v       = do_flush && fl_valid;
    e0.kind    = fl_kind;
    e0.start   = state_i.start;
    e0.len     = sat_len({1'b0, state_i.pos}, state_i.start);
    e0.line    = state_i.line;
    e0.err     = fl_err;
    e0.last    = 1'b0;

    e1.line    = state_i.line;
    e1.last    = 1'b1;
    if (do_sb && sb_emit) begin
      e1_v     = 1'b1;
      e1.kind  = sb_kind;
      e1.start = state_i.pos;
      e1.len   = LENGTH_BITS'(1);
      e1.err   = sb_err;
    end else begin
      e1_v     = own_valid;
      e1.kind  = own_kind;
      e1.start = own_start;
      e1.len   = own_len;
      e1.err   = ERR_NONE;
    end

    if (e0_v) begin
      tok0_o      = e0;
      tok0_o.last = !e1_v;
      tok1_o      = e1;
    end else begin
      tok0_o      = e1;
      tok1_o      = e1;
    end
    push_cnt_o = {1'b0, e0_v} + {1'b0, e1_v};
  end

endmodule

FILE: sv/lts_out_queue.sv
// Four-entry result queue taking up to two tokens per cycle, draining one.
// Depends on lts_pkg.
module lts_out_queue import lts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  tok_t       tok0_i,
  input  tok_t       tok1_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tok_t       tok_o
);

  tok_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  // room for a full pair of tokens
  assign room_o      = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign tok_o       = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= tok0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= tok1_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_cnt_i} - {2'b00, pop};
    end
  end

endmodule

FILE: sv/lox_token_scanner.sv
// Lox token scanner: byte stream in, token stream out.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one source byte per
//   transaction, or an end-of-text mark (end_of_input_i = 1) that flushes
//   any pending token and then yields an EOF token.
//   Output channel (out_valid_o / out_ready_i) carries one token per
//   transaction; last_in_run_o marks the final token caused by an input.
// Tokens for an input are written to the queue on the edge that accepts it.
//   Throughput: one byte per cycle while in_ready_o is high; a byte yields
//   0 to 2 tokens. The per-byte step is a single combinational pass over
//   the scanner registers; tokens land in a four-entry queue.
// Stall: in_ready_o stays high while the queue has room for two tokens;
//   a stalled receiver fills the queue and then holds off input.
// Reset: mode idle, offset 0, line 1, queue empty; no clearing pass.
// Depends on lts_pkg, lts_scan and lts_out_queue.
module lox_token_scanner import lts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             char_byte_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [5:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [1:0]             error_kind_o,
  output logic                   last_in_run_o
);

  scan_state_t state_q, state_d;
  tok_t        tok0, tok1, tok_out;
  logic [1:0]  scan_cnt, push_cnt;
  logic        room, accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && in_ready_o;
  assign push_cnt   = accept ? scan_cnt : 2'd0;

  // Per-byte scanner step
  lts_scan u_scan (
    .state_i        (state_q),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .state_o        (state_d),
    .tok0_o         (tok0),
    .tok1_o         (tok1),
    .push_cnt_o     (scan_cnt)
  );

  // Scanner state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= MODE_IDLE;
      state_q.pos   <= '0;
      state_q.start <= '0;
      state_q.line  <= LINE_BITS'(1);
      state_q.cand  <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result queue
  lts_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .tok0_i      (tok0),
    .tok1_i      (tok1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok_out)
  );

  assign token_kind_o   = tok_out.kind;
  assign start_offset_o = tok_out.start;
  assign token_length_o = tok_out.len;
  assign line_number_o  = tok_out.line;
  assign error_kind_o   = tok_out.err;
  assign last_in_run_o  = tok_out.last;

`ifndef NO_ASSERTIONS
  // token start never runs ahead of the byte offset
  a_start_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.start <= state_q.pos)
    else $error("token start beyond byte position");

  // line counter starts at one and saturates, never wraps to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line != '0)
    else $error("line count is zero");

  // end of text always leaves the scanner idle with an EOF token queued
  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_input_i) |=> (state_q.mode == MODE_IDLE) && out_valid_o)
    else $error("end of text did not flush the scanner");

  // end of text does not move the byte offset
  a_eof_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_input_i) |=> $stable(state_q.pos))
    else $error("byte position moved on end of text");
`endif

endmodule
